// ----- rtl/core/nns_pkg.sv -----
package nns_pkg;

  // operation codes of an input word
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIMENSIONS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_METRIC     = 1'd1;

  // metric codes
  localparam logic METRIC_L2 = 1'b0;
  localparam logic METRIC_L1 = 1'b1;

  // fixed field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned DIM_REG_W  = 5;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned DIST_W     = 37;

  // sample index carried along the scan pipeline, wide enough for the largest store
  localparam int unsigned TAG_SAMPLE_W = 12;

  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic [TAG_SAMPLE_W-1:0] sample;
  } scan_tag_t;

endpackage

// ----- rtl/core/nns_sample_mem.sv -----
module nns_sample_mem #(
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/nns_dist_unit.sv -----
module nns_dist_unit #(
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned ACC_W      = 36
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                metric,
  input  nns_pkg::scan_tag_t                  tag_in,
  input  logic [VALUE_BITS-1:0]               query_val,
  input  logic [VALUE_BITS-1:0]               sample_val,
  output logic                                busy,
  output logic [ACC_W-1:0]                    best_dist,
  output logic [nns_pkg::TAG_SAMPLE_W-1:0]    best_idx
);

  localparam int unsigned TERM_W = 2 * VALUE_BITS;

  nns_pkg::scan_tag_t tag_a;
  nns_pkg::scan_tag_t tag_b;
  logic [VALUE_BITS-1:0] absd;
  logic [TERM_W-1:0]     term;
  logic [ACC_W-1:0]      acc;
  logic                  have_best;

  logic signed [VALUE_BITS:0] diff;
  logic [VALUE_BITS:0]        diff_mag;
  logic [TERM_W-1:0]          sq;
  logic [ACC_W-1:0]           acc_sum;

  // stage a: absolute difference
  always_comb begin
    diff     = $signed({query_val[VALUE_BITS-1], query_val})
             - $signed({sample_val[VALUE_BITS-1], sample_val});
    diff_mag = diff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff) : (VALUE_BITS+1)'(diff);
  end

  // stage b: square or pass through
  assign sq = absd * absd;

  // stage c: accumulate, compare on the last coordinate
  assign acc_sum = acc + ACC_W'(term);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a <= '0;
      tag_b <= '0;
    end else begin
      tag_a <= tag_in;
      tag_b <= tag_a;
    end
  end

  always_ff @(posedge clk) begin
    absd <= diff_mag[VALUE_BITS-1:0];
    term <= (metric == nns_pkg::METRIC_L1) ? TERM_W'(absd) : sq;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc       <= '0;
      best_dist <= '0;
      best_idx  <= '0;
      have_best <= 1'b0;
    end else if (tag_b.valid) begin
      if (tag_b.last) begin
        acc <= '0;
        // strict less-than keeps the earliest sample on a tie
        if (!have_best || acc_sum < best_dist) begin
          best_dist <= acc_sum;
          best_idx  <= tag_b.sample;
          have_best <= 1'b1;
        end
      end else begin
        acc <= acc_sum;
      end
    end
  end

  assign busy = tag_a.valid | tag_b.valid;

endmodule

// ----- rtl/core/nearest_neighbor_search.sv -----
// Brute-force 1-nearest-neighbor search over a store of up to MAX_SAMPLES vectors of
// signed Q8.8 coordinates, one coordinate per input word. operation selects clear,
// append a sample coordinate, or give a query coordinate; a vector is complete when
// it holds "dimensions" coordinates (0 acts as 1, values above MAX_DIMS as MAX_DIMS),
// and appends to a full store are dropped. The word that completes a query starts a
// scan of every stored sample under the squared euclidean (metric 0) or manhattan
// (metric 1) distance and yields one result word: the first sample at the least
// distance, that distance and found (0 with index and distance 0 for an empty store).
// Clear, append and non-final query words leave in_ready high. A final query word
// starts a scan: one shared subtract / square / accumulate unit walks the sample
// memory one coordinate per cycle through its single read port, then its pipeline
// drains; in_ready stays low until the result is loaded. The result
// sits in an output register, so the next words are taken while it waits for
// out_ready; a further query result waits until that register is free.
module nearest_neighbor_search #(
  parameter int unsigned MAX_SAMPLES = 256,
  parameter int unsigned MAX_DIMS    = 16,
  parameter int unsigned VALUE_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [nns_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [nns_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input words
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [nns_pkg::OP_W-1:0]           operation,
  input  logic signed [VALUE_BITS-1:0]       coord_value,
  // result words
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               found,
  output logic [nns_pkg::INDEX_W-1:0]        nearest_index,
  output logic [nns_pkg::DIST_W-1:0]         best_distance
);

  // address split of the sample memory: {sample, coordinate}
  localparam int unsigned SAMP_AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned DIM_AW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned COUNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned DIM_CW  = $clog2(MAX_DIMS + 1);
  localparam int unsigned DCMP_W  = (DIM_CW > nns_pkg::DIM_REG_W) ? DIM_CW
                                                                 : nns_pkg::DIM_REG_W;
  localparam int unsigned MEM_AW  = SAMP_AW + DIM_AW;
  // exact distance width: MAX_DIMS terms of up to 2*VALUE_BITS bits
  localparam int unsigned ACC_W   = 2 * VALUE_BITS + $clog2(MAX_DIMS);
  localparam int unsigned EXT_W   = (ACC_W > nns_pkg::DIST_W) ? ACC_W : nns_pkg::DIST_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration
  logic [nns_pkg::DIM_REG_W-1:0] dimensions;
  logic                          metric;
  logic [DIM_CW-1:0]             dims_act;

  // store bookkeeping
  logic [COUNT_W-1:0] sample_count;
  logic [DIM_AW-1:0]  append_pos;
  logic [DIM_AW-1:0]  query_pos;
  logic [VALUE_BITS-1:0] query_buf [MAX_DIMS];
  logic [VALUE_BITS-1:0] query_rd;

  // scan sequencer
  logic [SAMP_AW-1:0] scan_s;
  logic [DIM_AW-1:0]  scan_j;
  logic               scan_last_dim;
  logic               scan_last_sample;
  nns_pkg::scan_tag_t tag_issue;
  nns_pkg::scan_tag_t tag_q;

  // handshake decode
  logic in_accept;
  logic do_clear;
  logic do_append;
  logic do_query;
  logic append_done;
  logic query_done;
  logic start_scan;
  logic out_free;

  // memory and distance unit
  logic [MEM_AW-1:0]     mem_wr_addr;
  logic [MEM_AW-1:0]     mem_rd_addr;
  logic [VALUE_BITS-1:0] sample_rd;
  logic                  dist_busy;
  logic [ACC_W-1:0]      best_dist;
  logic [nns_pkg::TAG_SAMPLE_W-1:0] best_idx;
  logic [EXT_W-1:0]      best_ext;

  // active dimension count, clamped to 1..MAX_DIMS
  always_comb begin
    priority if (dimensions == '0) begin
      dims_act = DIM_CW'(1);
    end else if (DCMP_W'(dimensions) > DCMP_W'(MAX_DIMS)) begin
      dims_act = DIM_CW'(MAX_DIMS);
    end else begin
      dims_act = DIM_CW'(dimensions);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dimensions <= nns_pkg::DIM_REG_W'(1);
      metric     <= nns_pkg::METRIC_L2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nns_pkg::REG_DIMENSIONS: dimensions <= cfg_data[nns_pkg::DIM_REG_W-1:0];
        nns_pkg::REG_METRIC:     metric     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid & in_ready;
  assign do_clear  = in_accept && (operation == nns_pkg::OP_CLEAR);
  assign do_append = in_accept && (operation == nns_pkg::OP_APPEND)
                     && (sample_count < COUNT_W'(MAX_SAMPLES));
  assign do_query  = in_accept && (operation == nns_pkg::OP_QUERY);

  // a vector is complete once its position reaches the active count, even if
  // dimensions was lowered while it was partly entered
  assign append_done = ((DIM_CW+1)'(append_pos) + 1'b1) >= (DIM_CW+1)'(dims_act);
  assign query_done  = ((DIM_CW+1)'(query_pos) + 1'b1) >= (DIM_CW+1)'(dims_act);
  assign start_scan  = do_query && query_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      append_pos   <= '0;
      query_pos    <= '0;
    end else if (do_clear) begin
      sample_count <= '0;
      append_pos   <= '0;
      query_pos    <= '0;
    end else begin
      if (do_append) begin
        if (append_done) begin
          append_pos   <= '0;
          sample_count <= sample_count + 1'b1;
        end else begin
          append_pos <= append_pos + 1'b1;
        end
      end
      if (do_query) begin
        query_pos <= query_done ? '0 : query_pos + 1'b1;
      end
    end
  end

  // query buffer, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (do_query) begin
      query_buf[query_pos] <= coord_value;
    end
    query_rd <= query_buf[scan_j];
  end

  assign mem_wr_addr = {sample_count[SAMP_AW-1:0], append_pos};
  assign mem_rd_addr = {scan_s, scan_j};

  nns_sample_mem #(
    .ADDR_W (MEM_AW),
    .DATA_W (VALUE_BITS)
  ) u_sample_mem (
    .clk     (clk),
    .wr_en   (do_append),
    .wr_addr (mem_wr_addr),
    .wr_data (coord_value),
    .rd_addr (mem_rd_addr),
    .rd_data (sample_rd)
  );

  // scan walks every coordinate of every stored sample, one per cycle
  assign scan_last_dim    = (DIM_CW'(scan_j) + 1'b1) == dims_act;
  assign scan_last_sample = (COUNT_W'(scan_s) + 1'b1) == sample_count;

  always_comb begin
    tag_issue        = '0;
    tag_issue.valid  = (state == ST_SCAN);
    tag_issue.last   = scan_last_dim;
    tag_issue.sample = nns_pkg::TAG_SAMPLE_W'(scan_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (start_scan) begin
      scan_s <= '0;
      scan_j <= '0;
    end else if (state == ST_SCAN) begin
      if (scan_last_dim) begin
        scan_j <= '0;
        scan_s <= scan_s + 1'b1;
      end else begin
        scan_j <= scan_j + 1'b1;
      end
    end
  end

  nns_dist_unit #(
    .VALUE_BITS (VALUE_BITS),
    .ACC_W      (ACC_W)
  ) u_dist_unit (
    .clk        (clk),
    .rst        (rst),
    .start      (start_scan),
    .metric     (metric),
    .tag_in     (tag_q),
    .query_val  (query_rd),
    .sample_val (sample_rd),
    .busy       (dist_busy),
    .best_dist  (best_dist),
    .best_idx   (best_idx)
  );

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_scan) begin
          // empty store skips straight to the result
          state_next = (sample_count == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last_dim && scan_last_sample) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!tag_q.valid && !dist_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result register
  assign best_ext = EXT_W'(best_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      found         <= (sample_count != '0);
      nearest_index <= best_idx[nns_pkg::INDEX_W-1:0];
      best_distance <= best_ext[nns_pkg::DIST_W-1:0];
    end
  end

  // the scan never reads past the stored samples
  assert property (@(posedge clk) disable iff (rst)
    tag_q.valid |-> (COUNT_W'(tag_q.sample) < sample_count))
    else $error("scan read beyond stored samples");

  // an empty store reports index and distance zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (nearest_index == '0 && best_distance == '0))
    else $error("empty-store result not zero");

  // no distance work is in flight while words are taken
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!tag_q.valid && !dist_busy))
    else $error("scan pipeline busy in idle");

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(best_distance)
                                   && $stable(nearest_index)))
    else $error("pending result changed");

endmodule

// ----- tb/nearest_neighbor_search_tb.sv -----
module nearest_neighbor_search_tb;

  // block sizes at their defaults
  localparam int unsigned SAMPLES = 256;
  localparam int unsigned DIMS    = 16;

  // operation code the block has no use for
  localparam logic [nns_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned TOTAL_WORDS = 1150;
  // watchdog limit: covers the longest scan plus stalls and the long hold
  localparam int unsigned STALL_LIMIT = 50000;
  localparam int unsigned LONG_HOLD   = 300;
  // cycles for non-final words to retire before a register write
  localparam int unsigned SETTLE      = 8;

  typedef struct packed {
    logic                        found;
    logic [nns_pkg::INDEX_W-1:0] index;
    logic [nns_pkg::DIST_W-1:0]  distance;
  } neighbor_t;

  logic                            clk         = 1'b0;
  logic                            rst         = 1'b1;
  logic                            cfg_we      = 1'b0;
  logic [nns_pkg::CFG_INDEX_W-1:0] cfg_index   = nns_pkg::REG_DIMENSIONS;
  logic [nns_pkg::CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                            in_valid    = 1'b0;
  logic                            in_ready;
  logic [nns_pkg::OP_W-1:0]        operation   = nns_pkg::OP_CLEAR;
  logic signed [15:0]              coord_value = '0;
  logic                            out_valid;
  logic                            out_ready   = 1'b0;
  logic                            found;
  logic [nns_pkg::INDEX_W-1:0]     nearest_index;
  logic [nns_pkg::DIST_W-1:0]      best_distance;

  nearest_neighbor_search dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .coord_value   (coord_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .nearest_index (nearest_index),
    .best_distance (best_distance)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predicted state of the block
  // ---------------------------------------------------------------------------
  logic signed [15:0]             sample_mem [SAMPLES][DIMS];
  logic signed [15:0]             query_vec [DIMS];
  int unsigned                    stored_samples = 0;
  int unsigned                    append_slot    = 0;
  int unsigned                    query_slot     = 0;
  logic [nns_pkg::CFG_DATA_W-1:0] dims_setting   = 5'd1;
  logic                           metric_setting = nns_pkg::METRIC_L2;

  // nearest-neighbor answers still owed by the block, oldest first
  neighbor_t nearest_due [$];

  // run bookkeeping
  int unsigned words_sent    = 0;
  int unsigned queries_done  = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;
  bit          quiet_tx      = 1'b0;
  bit          quiet_rx      = 1'b0;
  bit          long_hold_req = 1'b0;

  // 0 behaves as 1, anything past the store width as the full width
  function automatic int unsigned active_dims();
    if (dims_setting == 0) return 1;
    if (dims_setting > DIMS) return DIMS;
    return dims_setting;
  endfunction

  // scan every stored sample against the query buffer, first minimum wins
  function automatic neighbor_t search_store(int unsigned d);
    neighbor_t         best;
    longint unsigned   total;
    longint unsigned   gap;
    longint            diff;
    int unsigned       s;
    int unsigned       j;
    best = '0;
    for (s = 0; s < stored_samples; s++) begin
      total = 0;
      for (j = 0; j < d; j++) begin
        diff = longint'(query_vec[j]) - longint'(sample_mem[s][j]);
        gap  = (diff < 0) ? -diff : diff;
        total += (metric_setting == nns_pkg::METRIC_L1) ? gap : gap * gap;
      end
      if (s == 0 || total < best.distance) begin
        best.found    = 1'b1;
        best.index    = s[nns_pkg::INDEX_W-1:0];
        best.distance = total[nns_pkg::DIST_W-1:0];
      end
    end
    return best;
  endfunction

  // advance the predicted state by one accepted word
  function automatic void apply_word(logic [nns_pkg::OP_W-1:0] op,
                                     logic signed [15:0] value);
    int unsigned d;
    d = active_dims();
    case (op)
      nns_pkg::OP_CLEAR: begin
        stored_samples = 0;
        append_slot    = 0;
        query_slot     = 0;
      end
      nns_pkg::OP_APPEND: begin
        // a full store drops the coordinate
        if (stored_samples < SAMPLES) begin
          if (append_slot >= DIMS) append_slot = 0;
          sample_mem[stored_samples][append_slot] = value;
          append_slot++;
          if (append_slot >= d) begin
            append_slot = 0;
            stored_samples++;
          end
        end
      end
      nns_pkg::OP_QUERY: begin
        if (query_slot >= DIMS) query_slot = 0;
        query_vec[query_slot] = value;
        query_slot++;
        if (query_slot >= d) begin
          query_slot = 0;
          nearest_due = {nearest_due, search_store(d)};
          queries_done++;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one word after a random gap, return at the edge that takes it
  task automatic send_word(logic [nns_pkg::OP_W-1:0] op, logic signed [15:0] value);
    int unsigned gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    coord_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_word(op, value);
    if (op != OP_UNUSED) words_sent++;
  endtask

  // stop offering and wait until every answer is back and the block is quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (nearest_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register writes only happen with the block idle
  task automatic write_reg(logic [nns_pkg::CFG_INDEX_W-1:0] idx,
                           logic [nns_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == nns_pkg::REG_DIMENSIONS) dims_setting = data;
    else metric_setting = data[0];
  endtask

  // coordinates lean on the extremes and on a narrow band that breeds ties
  function automatic logic signed [15:0] pick_coord();
    logic [15:0] raw;
    int          near;
    raw  = 16'($urandom);
    near = int'($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2, 3: return near[15:0];
      default: return raw;
    endcase
  endfunction

  // a full query: either near a stored sample or anywhere
  task automatic send_query(int unsigned d);
    int unsigned pick;
    int unsigned j;
    int          v;
    if (stored_samples != 0 && $urandom_range(0, 1) == 1) begin
      pick = $urandom_range(0, stored_samples - 1);
      for (j = 0; j < d; j++) begin
        v = int'(sample_mem[pick][j]) + int'($urandom_range(0, 2)) - 1;
        send_word(nns_pkg::OP_QUERY, v[15:0]);
      end
    end else begin
      for (j = 0; j < d; j++) send_word(nns_pkg::OP_QUERY, pick_coord());
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stalls, plus one long hold when asked
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned pause;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        pause         = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        pause = quiet_rx ? 0 : $urandom_range(0, 11);
      end
      if (pause != 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // compare every taken result word against the oldest answer owed
  always @(posedge clk) begin : result_check
    neighbor_t got;
    neighbor_t want;
    if (!rst && out_valid && out_ready) begin
      got = {found, nearest_index, best_distance};
      results_seen++;
      if (nearest_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with no query pending: %s found=%0b index=%0d dist=%0d",
                   results_seen, "got", got.found, got.index, got.distance);
      end else begin
        want = nearest_due.pop_front();
        if (got.found !== want.found || got.index !== want.index ||
            got.distance !== want.distance) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected found=%0b index=%0d dist=%0d",
                     results_seen, want.found, want.index, want.distance);
            $display("result %0d: got      found=%0b index=%0d dist=%0d",
                     results_seen, got.found, got.index, got.distance);
          end
        end
      end
    end
  end

  // no handshake for too long means the block hung
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // queries on an empty store answer not-found; the spare opcode does nothing
  task automatic test_empty_store();
    send_word(nns_pkg::OP_QUERY, 16'sh8000);
    send_word(OP_UNUSED, 16'sh7fff);
  endtask

  // coordinate extremes under both metrics, largest per-axis differences
  task automatic test_extreme_values();
    write_reg(nns_pkg::REG_DIMENSIONS, 5'd2);
    send_word(nns_pkg::OP_CLEAR, 16'sh0000);
    send_word(nns_pkg::OP_APPEND, 16'sh8000);
    send_word(nns_pkg::OP_APPEND, 16'sh7fff);
    send_word(nns_pkg::OP_APPEND, 16'sh7fff);
    send_word(nns_pkg::OP_APPEND, 16'sh8000);
    send_word(nns_pkg::OP_QUERY, 16'sh7fff);
    send_word(nns_pkg::OP_QUERY, 16'sh8000);
    // upper data bits set, only bit 0 selects the metric
    write_reg(nns_pkg::REG_METRIC, {4'b1010, nns_pkg::METRIC_L1});
    send_word(nns_pkg::OP_QUERY, 16'sh8000);
    send_word(nns_pkg::OP_QUERY, 16'sh8000);
  endtask

  // equal distances must pick the earliest sample; dimension 0 acts as 1
  task automatic test_ties();
    write_reg(nns_pkg::REG_DIMENSIONS, 5'd0);
    send_word(nns_pkg::OP_CLEAR, 16'sh0000);
    send_word(nns_pkg::OP_APPEND, 16'sd7);
    send_word(nns_pkg::OP_APPEND, 16'sd3);
    send_word(nns_pkg::OP_APPEND, 16'sd7);
    send_word(nns_pkg::OP_QUERY, 16'sd5);
  endtask

  // shrinking the dimension count finishes partly entered vectors early
  task automatic test_dims_lowered_midway();
    write_reg(nns_pkg::REG_DIMENSIONS, 5'd3);
    send_word(nns_pkg::OP_CLEAR, 16'sh0000);
    send_word(nns_pkg::OP_APPEND, 16'sd10);
    send_word(nns_pkg::OP_APPEND, 16'sd20);
    send_word(nns_pkg::OP_QUERY, 16'sd11);
    write_reg(nns_pkg::REG_DIMENSIONS, 5'd1);
    send_word(nns_pkg::OP_APPEND, 16'sd30);
    send_word(nns_pkg::OP_QUERY, 16'sd50);
  endtask

  // clear throws away a half sample and a half query
  task automatic test_clear_drops_partials();
    write_reg(nns_pkg::REG_DIMENSIONS, 5'd2);
    send_word(nns_pkg::OP_CLEAR, 16'sh0000);
    send_word(nns_pkg::OP_APPEND, 16'sd100);
    send_word(nns_pkg::OP_QUERY, 16'sd1);
    send_word(nns_pkg::OP_CLEAR, 16'sh0000);
    send_word(nns_pkg::OP_APPEND, 16'sd8);
    send_word(nns_pkg::OP_APPEND, 16'sd9);
    send_word(nns_pkg::OP_QUERY, 16'sd8);
    send_word(nns_pkg::OP_QUERY, 16'sd9);
  endtask

  // fill all 256 slots, then show that further appends are dropped
  task automatic test_full_store();
    int unsigned k;
    int          v;
    write_reg(nns_pkg::REG_DIMENSIONS, 5'd1);
    write_reg(nns_pkg::REG_METRIC, {4'b0000, nns_pkg::METRIC_L2});
    send_word(nns_pkg::OP_CLEAR, 16'sh0000);
    for (k = 0; k < SAMPLES - 1; k++) begin
      v = int'($urandom_range(0, 60000)) - 30000;
      send_word(nns_pkg::OP_APPEND, v[15:0]);
    end
    // last slot is the only one out at the top edge
    send_word(nns_pkg::OP_APPEND, 16'sh7fff);
    repeat (4) send_word(nns_pkg::OP_APPEND, 16'sh8000);
    send_word(nns_pkg::OP_QUERY, 16'sh7fff);
    send_word(nns_pkg::OP_QUERY, 16'sh8000);
    write_reg(nns_pkg::REG_METRIC, {4'b0101, nns_pkg::METRIC_L1});
    send_word(nns_pkg::OP_QUERY, 16'sh0000);
  endtask

  // long receiver hold while queries keep coming: output register fills and
  // the input stalls; then the sender waits for every answer
  task automatic test_output_stall();
    write_reg(nns_pkg::REG_DIMENSIONS, 5'd1);
    send_word(nns_pkg::OP_CLEAR, 16'sh0000);
    send_word(nns_pkg::OP_APPEND, 16'sd40);
    send_word(nns_pkg::OP_APPEND, -16'sd40);
    send_word(nns_pkg::OP_APPEND, 16'sd0);
    long_hold_req = 1'b1;
    quiet_tx      = 1'b1;
    repeat (8) send_word(nns_pkg::OP_QUERY, pick_coord());
    quiet_tx = 1'b0;
    wait_idle();
  endtask

  // random data sets: mostly clean sample/query sequences, some noise
  task automatic test_random_sets();
    logic [nns_pkg::CFG_DATA_W-1:0] d_raw;
    logic [nns_pkg::CFG_DATA_W-1:0] m_raw;
    int unsigned                    d;
    int unsigned                    nsamp;
    int unsigned                    k;
    int unsigned                    j;
    while (words_sent < TOTAL_WORDS) begin
      case ($urandom_range(0, 9))
        0: d_raw = 5'd0;
        1: d_raw = 5'($urandom_range(17, 31));
        2, 3: d_raw = 5'($urandom_range(5, 16));
        default: d_raw = 5'($urandom_range(1, 4));
      endcase
      write_reg(nns_pkg::REG_DIMENSIONS, d_raw);
      if ($urandom_range(0, 1) == 1) begin
        m_raw = 5'($urandom);
        write_reg(nns_pkg::REG_METRIC, m_raw);
      end
      quiet_tx = ($urandom_range(0, 4) == 0);
      quiet_rx = ($urandom_range(0, 4) == 0);
      d = active_dims();
      // always start from an empty store so no unwritten coordinate is scanned
      send_word(nns_pkg::OP_CLEAR, pick_coord());
      nsamp = $urandom_range(0, 40 / d + 1);
      for (k = 0; k < nsamp; k++) begin
        for (j = 0; j < d; j++) send_word(nns_pkg::OP_APPEND, pick_coord());
        case ($urandom_range(0, 19))
          0, 1, 2: send_query(d);
          3: send_word(OP_UNUSED, pick_coord());
          // stray coordinates knock the vectors out of step
          4: send_word(nns_pkg::OP_QUERY, pick_coord());
          5: send_word(nns_pkg::OP_APPEND, pick_coord());
          6: send_word(nns_pkg::OP_CLEAR, pick_coord());
          default: begin
          end
        endcase
      end
      repeat ($urandom_range(1, 4)) send_query(d);
    end
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
  endtask

  initial begin : run
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_empty_store();
    test_extreme_values();
    test_ties();
    test_dims_lowered_midway();
    test_clear_drops_partials();
    test_full_store();
    test_output_stall();
    test_random_sets();

    // drain the last answers, then give the block a few more cycles
    wait_idle();
    repeat (SETTLE) @(posedge clk);

    $display("sent %0d words with %0d completed queries, checked %0d result words",
             words_sent, queries_done, results_seen);
    $display("dims 0..31, both metrics, ties, full store and a %0d-cycle output hold",
             LONG_HOLD);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatching result words", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
